### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SPQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// Stable priority queue package
// Shared codes, state type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned PriW      = 8;
  localparam int unsigned OccW      = 4;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### rtl/core/spq_ctrl.sv
// ---------------------------------------------------------------------------
// Stable priority queue controller
// Accepts an item, then runs it once the result register can take it.
// ---------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = spq_pkg::ST_IDLE;
        end
      end
      default: state_d = spq_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/core/spq_datapath.sv
// ---------------------------------------------------------------------------
// Stable priority queue datapath
// Register row in arrival order, max search tree, shift-down and result register.
// ---------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_pkg::cmd_t                cmd_i,
  output spq_pkg::sts_t                sts_o,
  input  logic                         kind_i,
  input  logic [spq_pkg::ValueW-1:0]   value_i,
  input  logic [spq_pkg::PriW-1:0]     priority_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spq_pkg::ValueW-1:0]   value_o,
  output logic [spq_pkg::StatusW-1:0]  status_o,
  output logic [spq_pkg::OccW-1:0]     occupancy_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned Leaves = 1 << IdxW;

  logic [spq_pkg::ValueW-1:0] val_q [DEPTH];
  logic [spq_pkg::PriW-1:0]   pri_q [DEPTH];
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       kind_q;
  logic [spq_pkg::ValueW-1:0] in_val_q;
  logic [spq_pkg::PriW-1:0]   in_pri_q;
  logic [IdxW-1:0]            best_q;

  logic                        out_valid_q, out_valid_d;
  logic [spq_pkg::ValueW-1:0]  out_val_q, out_val_d;
  logic [spq_pkg::StatusW-1:0] out_st_q, out_st_d;
  logic [spq_pkg::OccW-1:0]    out_occ_q, out_occ_d;

  logic                        full, empty, do_enq, do_deq;

  logic [spq_pkg::PriW-1:0] t_pri [2*Leaves];
  logic [IdxW-1:0]          t_idx [2*Leaves];
  logic                     t_vld [2*Leaves];

  // Search tree: the left child wins ties so the earliest entry is served.
  always_comb begin
    for (int n = 0; n < 2 * Leaves; n++) begin
      t_pri[n] = '0;
      t_idx[n] = '0;
      t_vld[n] = 1'b0;
    end
    for (int i = 0; i < Leaves; i++) begin
      if (i < DEPTH) begin
        t_pri[Leaves+i] = pri_q[i];
        t_vld[Leaves+i] = (CntW'(i) < cnt_q);
      end
      t_idx[Leaves+i] = IdxW'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      if (t_vld[2*n] && (!t_vld[2*n+1] || (t_pri[2*n] >= t_pri[2*n+1]))) begin
        t_pri[n] = t_pri[2*n];
        t_idx[n] = t_idx[2*n];
      end else begin
        t_pri[n] = t_pri[2*n+1];
        t_idx[n] = t_idx[2*n+1];
      end
      t_vld[n] = t_vld[2*n] || t_vld[2*n+1];
    end
  end

  assign full   = (cnt_q == CntW'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign do_enq = cmd_i.exec && (kind_q == spq_pkg::KIND_ENQ) && !full;
  assign do_deq = cmd_i.exec && (kind_q == spq_pkg::KIND_DEQ) && !empty;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_occ_d   = out_occ_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      out_val_d   = '0;
      out_st_d    = spq_pkg::STATUS_DONE;
      if (kind_q == spq_pkg::KIND_ENQ) begin
        if (full) begin
          out_st_d = spq_pkg::STATUS_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          out_st_d = spq_pkg::STATUS_EMPTY;
        end else begin
          out_val_d = val_q[best_q];
          cnt_d     = cnt_q - CntW'(1);
        end
      end
      out_occ_d = spq_pkg::OccW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_st_q  <= out_st_d;
    out_occ_q <= out_occ_d;
    if (cmd_i.latch) begin
      kind_q   <= kind_i;
      in_val_q <= value_i;
      in_pri_q <= priority_i;
      best_q   <= t_idx[1];
    end
    if (do_enq) begin
      val_q[cnt_q[IdxW-1:0]] <= in_val_q;
      pri_q[cnt_q[IdxW-1:0]] <= in_pri_q;
    end
    if (do_deq) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IdxW'(i) >= best_q) begin
          val_q[i] <= val_q[i+1];
          pri_q[i] <= pri_q[i+1];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign status_o    = out_st_q;
  assign occupancy_o = out_occ_q;

endmodule

### rtl/core/stable_priority_queue_top.sv
// ---------------------------------------------------------------------------
// Stable priority queue
// Bounded queue of value and priority pairs, served highest priority first.
// ---------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the kind (enqueue or
// dequeue), tdata the value and priority. Each item produces exactly one
// result item on the m_axis channel: tdata carries the removed value and the
// occupancy, tuser the status (done, rejected because full, rejected because
// empty). Among equal priorities the earliest entry is served first.
// In the accept cycle the search tree over the register row picks the best
// entry. Once the result register can take the result, the row is appended to
// or shifted down and the result register is loaded; a new item is accepted
// only after the result of the previous one has been loaded. A result that
// waits in the output register does not block acceptance; the block holds the
// following item until that result has been taken.
// Reset empties the queue and clears the result valid flag; the result data
// registers are not reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] value_in, [39:32] priority_in
  input  logic [39:0] s_axis_tdata_i,
  // [0] kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] value_out, [35:32] occupancy, [39:36] zero
  output logic [39:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  spq_pkg::cmd_t               cmd;
  spq_pkg::sts_t               sts;
  logic [spq_pkg::ValueW-1:0]  value_out;
  logic [spq_pkg::StatusW-1:0] status;
  logic [spq_pkg::OccW-1:0]    occupancy;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i[31:0]),
    .priority_i  (s_axis_tdata_i[39:32]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .value_o     (value_out),
    .status_o    (status),
    .occupancy_o (occupancy)
  );

  assign m_axis_tdata_o = {4'b0000, occupancy, value_out};
  assign m_axis_tuser_o = status;

  `SPQ_ASSERT(a_accept_then_busy, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "item accepted while previous item still executing")
  `SPQ_ASSERT(a_exec_needs_room, cmd.exec |-> sts.out_free, "result register overwritten before it was taken")
  `SPQ_ASSERT(a_full_occ, (m_axis_tvalid_o && (status == spq_pkg::STATUS_FULL)) |-> (occupancy == spq_pkg::OccW'(DEPTH)), "full status without full occupancy")
  `SPQ_ASSERT(a_empty_res, (m_axis_tvalid_o && (status == spq_pkg::STATUS_EMPTY)) |-> ((occupancy == '0) && (value_out == '0)), "empty status with non-zero result")

endmodule
